// File: rtl/core/npsch_pkg.sv
// Shared constants, types and control structs for the priority scheduler.
// No dependencies; compile first.
`default_nettype none

package npsch_pkg;

    // Job set size and derived widths
    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

    // Field widths
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 16;
    localparam int TICK_W = 24;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TICK_W-1:0] tick_t;

    // One stored job
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
        logic [PRIO_W-1:0] prio;
    } job_rec_t;

    // Sequencer to job store
    typedef struct packed {
        logic  load_en;
        idx_t  load_idx;
        logic  commit_en;
        idx_t  commit_idx;
        tick_t commit_wait;
        logic  clear_flags;
        idx_t  rd_idx;
    } store_ctrl_t;

    // Selection unit status after a scan round
    typedef struct packed {
        logic              found;
        logic              any_pending;
        idx_t              best_idx;
        logic [TIME_W-1:0] best_burst;
        logic [TIME_W-1:0] best_arrival;
        logic [TIME_W-1:0] earliest;
    } sel_state_t;

endpackage

`default_nettype wire

// File: rtl/core/npsch_job_if.sv
// Input channel carrying one job item per handshake.
// Depends on npsch_pkg.
`default_nettype none

interface npsch_job_if;
    import npsch_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] burst_time;
    logic [TIME_W-1:0] arrival_time;
    logic [PRIO_W-1:0] priority_value;
    logic              final_job;

    modport source (
        output valid, job_id, burst_time, arrival_time, priority_value, final_job,
        input  ready
    );

    modport sink (
        input  valid, job_id, burst_time, arrival_time, priority_value, final_job,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/npsch_res_if.sv
// Output channel carrying one per-job result item per handshake.
// Depends on npsch_pkg.
`default_nettype none

interface npsch_res_if;
    import npsch_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] result_job_id;
    tick_t           wait_ticks;
    tick_t           turnaround_ticks;
    logic            last_result;

    modport source (
        output valid, result_job_id, wait_ticks, turnaround_ticks, last_result,
        input  ready
    );

    modport sink (
        input  valid, result_job_id, wait_ticks, turnaround_ticks, last_result,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/npsch_job_store.sv
// Per-slot job storage: job fields, computed wait times and finished flags.
// Depends on npsch_pkg.
`default_nettype none

module npsch_job_store (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire npsch_pkg::store_ctrl_t ctrl,
    input  wire npsch_pkg::job_rec_t    wr_rec,
    output npsch_pkg::job_rec_t         rd_rec,
    output npsch_pkg::tick_t            rd_wait,
    output logic                        rd_finished
);
    import npsch_pkg::*;

    job_rec_t                 rec_mem [MAX_PROCESSES];
    tick_t                    wait_mem [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] finished_reg;
    logic [MAX_PROCESSES-1:0] finished_next;

    // Write job fields on load, wait time on commit
    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            rec_mem[ctrl.load_idx] <= wr_rec;
        end
        if (ctrl.commit_en)
        begin
            wait_mem[ctrl.commit_idx] <= ctrl.commit_wait;
        end
    end

    // Update finished flags: clear a slot on load, set it on commit, drop the whole set at batch end
    always_comb
    begin
        finished_next = finished_reg;
        if (ctrl.clear_flags)
        begin
            finished_next = '0;
        end
        else
        begin
            if (ctrl.load_en)
            begin
                finished_next[ctrl.load_idx] = 1'b0;
            end
            if (ctrl.commit_en)
            begin
                finished_next[ctrl.commit_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg <= '0;
        end
        else
        begin
            finished_reg <= finished_next;
        end
    end

    // Single read port shared by the scan and the result phases
    assign rd_rec      = rec_mem[ctrl.rd_idx];
    assign rd_wait     = wait_mem[ctrl.rd_idx];
    assign rd_finished = finished_reg[ctrl.rd_idx];

endmodule

`default_nettype wire

// File: rtl/core/npsch_select_unit.sv
// Shared compare unit: visits one stored job per cycle and keeps the most
// urgent arrived job and the earliest pending arrival. Depends on npsch_pkg.
`default_nettype none

module npsch_select_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                clear,
    input  wire logic                step,
    input  wire npsch_pkg::idx_t     entry_idx,
    input  wire npsch_pkg::job_rec_t entry,
    input  wire logic                entry_finished,
    input  wire npsch_pkg::tick_t    sim_clock,
    output npsch_pkg::sel_state_t    sel
);
    import npsch_pkg::*;

    logic              found_reg,    found_next;
    logic              any_reg,      any_next;
    idx_t              idx_reg,      idx_next;
    logic [PRIO_W-1:0] prio_reg,     prio_next;
    logic [TIME_W-1:0] burst_reg,    burst_next;
    logic [TIME_W-1:0] arrival_reg,  arrival_next;
    logic [TIME_W-1:0] earliest_reg, earliest_next;

    logic arrived;
    logic more_urgent;
    logic earlier;

    assign arrived     = TICK_W'(entry.arrival) <= sim_clock;
    assign more_urgent = !found_reg || (entry.prio < prio_reg);
    assign earlier     = !any_reg || (entry.arrival < earliest_reg);

    // Fold one entry into the running best; ties keep the lower index
    always_comb
    begin
        found_next    = found_reg;
        any_next      = any_reg;
        idx_next      = idx_reg;
        prio_next     = prio_reg;
        burst_next    = burst_reg;
        arrival_next  = arrival_reg;
        earliest_next = earliest_reg;
        if (clear)
        begin
            found_next = 1'b0;
            any_next   = 1'b0;
        end
        else if (step && !entry_finished)
        begin
            any_next = 1'b1;
            if (earlier)
            begin
                earliest_next = entry.arrival;
            end
            if (arrived && more_urgent)
            begin
                found_next   = 1'b1;
                idx_next     = entry_idx;
                prio_next    = entry.prio;
                burst_next   = entry.burst;
                arrival_next = entry.arrival;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        prio_reg     <= prio_next;
        burst_reg    <= burst_next;
        arrival_reg  <= arrival_next;
        earliest_reg <= earliest_next;
    end

    assign sel.found        = found_reg;
    assign sel.any_pending  = any_reg;
    assign sel.best_idx     = idx_reg;
    assign sel.best_burst   = burst_reg;
    assign sel.best_arrival = arrival_reg;
    assign sel.earliest     = earliest_reg;

endmodule

`default_nettype wire

// File: rtl/core/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler. Jobs load at one item per cycle into a
// set of up to MAX_PROCESSES slots; a job flagged final, or the one filling the
// last slot, closes the set. Scheduling then runs in rounds: each round the
// shared compare unit visits the N stored jobs one per cycle and a commit
// step follows. N rounds pick jobs and up to N more advance an idle clock to
// the next arrival before results start. Results then leave one per cycle
// while the sink is ready, in load order, through a registered output stage.
// The input is not ready from the job that closes the set until the last
// result has entered the output register.
// Depends on npsch_pkg, npsch_job_if, npsch_res_if, npsch_job_store and
// npsch_select_unit.
`default_nettype none

module nonpreemptive_priority_scheduler (
    input  wire logic   clk,
    input  wire logic   rst_n,
    npsch_job_if.sink   jobs,
    npsch_res_if.source results
);
    import npsch_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg,    state_next;
    cnt_t   count_reg,    count_next;
    cnt_t   done_reg,     done_next;
    idx_t   scan_idx_reg, scan_idx_next;
    idx_t   out_idx_reg,  out_idx_next;
    tick_t  clock_reg,    clock_next;
    logic   out_valid_reg, out_valid_next;

    logic [ID_W-1:0] res_id_reg;
    tick_t           res_wait_reg;
    tick_t           res_turn_reg;
    logic            res_last_reg;

    store_ctrl_t ctrl;
    job_rec_t    wr_rec;
    job_rec_t    rd_rec;
    tick_t       rd_wait;
    logic        rd_finished;
    sel_state_t  sel;

    idx_t slot;
    cnt_t count_after_load;
    logic load_fire;
    logic set_closed;
    logic scan_last;
    logic emit_fire;
    logic emit_last;
    cnt_t done_inc;

    // Handshake and phase conditions
    assign jobs.ready       = (state_reg == ST_LOAD);
    assign load_fire        = jobs.valid && jobs.ready;
    assign slot             = (count_reg >= cnt_t'(MAX_PROCESSES)) ?
                              idx_t'(MAX_PROCESSES - 1) : count_reg[IDX_W-1:0];
    assign count_after_load = cnt_t'(slot) + cnt_t'(1);
    assign set_closed       = jobs.final_job ||
                              (count_after_load == cnt_t'(MAX_PROCESSES));
    assign scan_last        = (cnt_t'(scan_idx_reg) + cnt_t'(1)) == count_reg;
    assign emit_fire        = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready);
    assign emit_last        = (cnt_t'(out_idx_reg) + cnt_t'(1)) == count_reg;
    assign done_inc         = done_reg + cnt_t'(1);

    assign wr_rec.id      = jobs.job_id;
    assign wr_rec.burst   = jobs.burst_time;
    assign wr_rec.arrival = jobs.arrival_time;
    assign wr_rec.prio    = jobs.priority_value;

    // Store control
    assign ctrl.load_en     = load_fire;
    assign ctrl.load_idx    = slot;
    assign ctrl.commit_en   = (state_reg == ST_COMMIT) && sel.found;
    assign ctrl.commit_idx  = sel.best_idx;
    assign ctrl.commit_wait = clock_reg - TICK_W'(sel.best_arrival);
    assign ctrl.clear_flags = emit_fire && emit_last;
    assign ctrl.rd_idx      = (state_reg == ST_EMIT) ? out_idx_reg : scan_idx_reg;

    npsch_job_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .wr_rec      (wr_rec),
        .rd_rec      (rd_rec),
        .rd_wait     (rd_wait),
        .rd_finished (rd_finished)
    );

    npsch_select_unit u_select (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (load_fire || (state_reg == ST_COMMIT)),
        .step           (state_reg == ST_SCAN),
        .entry_idx      (scan_idx_reg),
        .entry          (rd_rec),
        .entry_finished (rd_finished),
        .sim_clock      (clock_reg),
        .sel            (sel)
    );

    // Sequencer: load, scan rounds with commit, then emit
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        done_next     = done_reg;
        scan_idx_next = scan_idx_reg;
        out_idx_next  = out_idx_reg;
        clock_next    = clock_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    count_next = count_after_load;
                    if (set_closed)
                    begin
                        state_next    = ST_SCAN;
                        scan_idx_next = '0;
                        done_next     = '0;
                        clock_next    = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + idx_t'(1);
                end
            end
            ST_COMMIT:
            begin
                scan_idx_next = '0;
                if (sel.found)
                begin
                    clock_next = clock_reg + TICK_W'(sel.best_burst);
                    done_next  = done_inc;
                    if (done_inc == count_reg)
                    begin
                        state_next   = ST_EMIT;
                        out_idx_next = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    // Idle: jump to the earliest pending arrival
                    clock_next = TICK_W'(sel.earliest);
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_idx_next = out_idx_reg + idx_t'(1);
                    if (emit_last)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        done_next  = '0;
                        clock_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold a result until taken; refill when the stage frees up
    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            done_reg      <= '0;
            scan_idx_reg  <= '0;
            out_idx_reg   <= '0;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            scan_idx_reg  <= scan_idx_next;
            out_idx_reg   <= out_idx_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            res_id_reg   <= rd_rec.id;
            res_wait_reg <= rd_wait;
            res_turn_reg <= rd_wait + TICK_W'(rd_rec.burst);
            res_last_reg <= emit_last;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.result_job_id    = res_id_reg;
    assign results.wait_ticks       = res_wait_reg;
    assign results.turnaround_ticks = res_turn_reg;
    assign results.last_result      = res_last_reg;

    // Checks on the sequencer
    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg <= count_reg)
        else $error("scheduled job count exceeds loaded job count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_PROCESSES))
        else $error("job count exceeds capacity");

    a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && jobs.final_job) |=> (state_reg == ST_SCAN))
        else $error("final job did not start scheduling");

    a_idle_forward: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMMIT) && !sel.found)
            |-> (sel.any_pending && (TICK_W'(sel.earliest) > clock_reg)))
        else $error("idle advance does not move the clock forward");

    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_last) |=> ((state_reg == ST_LOAD) && (count_reg == '0)))
        else $error("batch not cleared after last result");

endmodule

`default_nettype wire
